[rtl/lcv_pkg.sv]
package lcv_pkg;

    localparam int COORD_BITS          = 12;
    localparam int DIFF_BITS           = COORD_BITS + 1;
    localparam int OUT_BITS            = 20;
    localparam int OUT_FRAC            = 8;
    localparam int NUM_EDGES           = 4;
    localparam int NUM_COORDS          = 4;
    localparam int CFG_IDX_BITS        = 3;
    localparam int PARAM_FRAC_BITS_DEF = 16;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic        [COORD_BITS-1:0] mag_t;
    typedef logic signed [OUT_BITS-1:0]   out_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WIN_LEFT    = 3'd0,
        REG_WIN_BOTTOM  = 3'd1,
        REG_WIN_RIGHT   = 3'd2,
        REG_WIN_TOP     = 3'd3,
        REG_VIEW_LEFT   = 3'd4,
        REG_VIEW_BOTTOM = 3'd5,
        REG_VIEW_RIGHT  = 3'd6,
        REG_VIEW_TOP    = 3'd7
    } cfg_reg_t;

    localparam coord_t WIN_LEFT_RST    = coord_t'(0);
    localparam coord_t WIN_BOTTOM_RST  = coord_t'(0);
    localparam coord_t WIN_RIGHT_RST   = coord_t'(100);
    localparam coord_t WIN_TOP_RST     = coord_t'(100);
    localparam coord_t VIEW_LEFT_RST   = coord_t'(0);
    localparam coord_t VIEW_BOTTOM_RST = coord_t'(0);
    localparam coord_t VIEW_RIGHT_RST  = coord_t'(100);
    localparam coord_t VIEW_TOP_RST    = coord_t'(100);

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } seg_t;

    typedef struct packed {
        logic visible;
        out_t view_start_x;
        out_t view_start_y;
        out_t view_end_x;
        out_t view_end_y;
    } res_t;

endpackage

[rtl/lcv_div.sv]
// Restoring divider, one quotient bit per stage, free running.
// Quotient saturates to all ones when it would not fit.
module lcv_div
    import lcv_pkg::*;
#(
    parameter int NUM_BITS = COORD_BITS + PARAM_FRAC_BITS_DEF,
    parameter int DEN_BITS = COORD_BITS,
    parameter int QUO_BITS = PARAM_FRAC_BITS_DEF + 1
)
(
    input  logic                clk,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic [QUO_BITS-1:0] quo
);

    localparam int RW = (NUM_BITS > DEN_BITS + QUO_BITS) ? NUM_BITS : DEN_BITS + QUO_BITS;

    logic [RW-1:0]       rem_reg [0:QUO_BITS-1];
    logic [DEN_BITS-1:0] den_reg [0:QUO_BITS-1];
    logic [QUO_BITS-1:0] quo_reg [0:QUO_BITS];
    logic                ovf_reg [0:QUO_BITS];
    logic [RW:0]         lim;

    always_comb
    begin
        lim = (RW+1)'(den) << QUO_BITS;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= RW'(num);
        den_reg[0] <= den;
        quo_reg[0] <= '0;
        ovf_reg[0] <= (RW+1)'(num) >= lim;
    end

    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_stage
        localparam int BIT = QUO_BITS - 1 - k;
        logic [RW-1:0]       shifted;
        logic                take;
        logic [QUO_BITS-1:0] quo_next;

        always_comb
        begin
            shifted       = RW'(den_reg[k]) << BIT;
            take          = rem_reg[k] >= shifted;
            quo_next      = quo_reg[k];
            quo_next[BIT] = take;
        end

        always_ff @(posedge clk)
        begin
            quo_reg[k+1] <= quo_next;
            ovf_reg[k+1] <= ovf_reg[k];
        end

        if (k < QUO_BITS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                rem_reg[k+1] <= take ? rem_reg[k] - shifted : rem_reg[k];
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    assign quo = ovf_reg[QUO_BITS] ? '1 : quo_reg[QUO_BITS];

endmodule

[rtl/line_clip_window_to_viewport_core.sv]
// From start to done each segment passes through the pipelined ratio dividers and the
// pipelined mapping dividers.
// Throughput: one item per cycle; busy is never raised and the receiver cannot stall.
// Reset: rst_n clears all valid bits and loads the window and viewport reset values.
module line_clip_window_to_viewport_core
    import lcv_pkg::*;
#(
    parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  seg_t                    segment,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  coord_t                  cfg_data,
    output logic                    done,
    output res_t                    result
);

    // widths of the parameter path
    localparam int U_BITS  = PARAM_FRAC_BITS + 1;          // holds 1.0 + 1 ulp
    localparam int LR      = PARAM_FRAC_BITS + 2;          // side-data delay matched to the ratio dividers
    localparam int PR_BITS = U_BITS + 1 + DIFF_BITS;       // u * d
    localparam int X_BITS  = COORD_BITS + PARAM_FRAC_BITS + 4;
    localparam int SH      = PARAM_FRAC_BITS - OUT_FRAC;
    localparam int A_BITS  = COORD_BITS + 10;              // point relative to window
    localparam int T_BITS  = A_BITS + DIFF_BITS;
    localparam int N_BITS  = T_BITS + 2;
    localparam int M_BITS  = N_BITS - 1;
    localparam int QB      = OUT_BITS + 1;                 // mapped quotient, saturating
    localparam int LM      = QB + 1;                       // side-data delay matched to the mapping dividers
    localparam int V_BITS  = QB + 2;

    localparam logic [U_BITS-1:0]        U_ONE = U_BITS'(1) << PARAM_FRAC_BITS;
    localparam logic [U_BITS-1:0]        U_CAP = U_ONE + U_BITS'(1);
    localparam logic signed [X_BITS-1:0] RND   = X_BITS'((2 ** SH) / 2);
    localparam logic signed [V_BITS-1:0] V_MAX = V_BITS'((2 ** (OUT_BITS - 1)) - 1);
    localparam logic signed [V_BITS-1:0] V_MIN = -V_BITS'(2 ** (OUT_BITS - 1));

    assign busy = 1'b0;

    // ---------------------------------------------------------------- config
    coord_t wl_reg, wb_reg, wr_reg, wt_reg, vl_reg, vb_reg, vr_reg, vt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= WIN_LEFT_RST;
            wb_reg <= WIN_BOTTOM_RST;
            wr_reg <= WIN_RIGHT_RST;
            wt_reg <= WIN_TOP_RST;
            vl_reg <= VIEW_LEFT_RST;
            vb_reg <= VIEW_BOTTOM_RST;
            vr_reg <= VIEW_RIGHT_RST;
            vt_reg <= VIEW_TOP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIN_LEFT:    wl_reg <= cfg_data;
                REG_WIN_BOTTOM:  wb_reg <= cfg_data;
                REG_WIN_RIGHT:   wr_reg <= cfg_data;
                REG_WIN_TOP:     wt_reg <= cfg_data;
                REG_VIEW_LEFT:   vl_reg <= cfg_data;
                REG_VIEW_BOTTOM: vb_reg <= cfg_data;
                REG_VIEW_RIGHT:  vr_reg <= cfg_data;
                REG_VIEW_TOP:    vt_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // spans use live config: the user changes it only while the pipe is empty; not enforced
    diff_t w_span_x, w_span_y, v_span_x, v_span_y;

    always_comb
    begin
        w_span_x = diff_t'(wr_reg) - diff_t'(wl_reg);
        w_span_y = diff_t'(wt_reg) - diff_t'(wb_reg);
        v_span_x = diff_t'(vr_reg) - diff_t'(vl_reg);
        v_span_y = diff_t'(vt_reg) - diff_t'(vb_reg);
    end

    // ---------------------------------------------------------------- S0: capture
    logic s0_vld_reg;
    seg_t s0_seg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else
            s0_vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s0_seg_reg <= segment;
    end

    // ---------------------------------------------------------------- SA: edge setup
    // Edges left, right, bottom, top as (p, q). Entry edges: p<0 and q<0.
    // Exit edges: p>0, q>=0. Early reject: p>=0 with q<0.
    typedef struct packed {
        logic [NUM_EDGES-1:0] entry;
        logic [NUM_EDGES-1:0] exit_e;
        logic                 ok;
        coord_t               x1;
        coord_t               y1;
        diff_t                dx;
        diff_t                dy;
    } side_t;

    diff_t                edge_p [NUM_EDGES];
    diff_t                edge_q [NUM_EDGES];
    mag_t                 num_next [NUM_EDGES];
    mag_t                 den_next [NUM_EDGES];
    side_t                sa_next;
    logic [NUM_EDGES-1:0] rej;

    always_comb
    begin
        sa_next.x1 = s0_seg_reg.start_x;
        sa_next.y1 = s0_seg_reg.start_y;
        sa_next.dx = diff_t'(s0_seg_reg.end_x) - diff_t'(s0_seg_reg.start_x);
        sa_next.dy = diff_t'(s0_seg_reg.end_y) - diff_t'(s0_seg_reg.start_y);
        edge_p[0]  = -sa_next.dx;
        edge_q[0]  = diff_t'(s0_seg_reg.start_x) - diff_t'(wl_reg);
        edge_p[1]  = sa_next.dx;
        edge_q[1]  = diff_t'(wr_reg) - diff_t'(s0_seg_reg.start_x);
        edge_p[2]  = -sa_next.dy;
        edge_q[2]  = diff_t'(s0_seg_reg.start_y) - diff_t'(wb_reg);
        edge_p[3]  = sa_next.dy;
        edge_q[3]  = diff_t'(wt_reg) - diff_t'(s0_seg_reg.start_y);
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            sa_next.entry[e]  = edge_p[e][DIFF_BITS-1] && edge_q[e][DIFF_BITS-1];
            sa_next.exit_e[e] = !edge_p[e][DIFF_BITS-1] && (edge_p[e] != '0)
                                && !edge_q[e][DIFF_BITS-1];
            rej[e]            = !edge_p[e][DIFF_BITS-1] && edge_q[e][DIFF_BITS-1];
            num_next[e] = edge_q[e][DIFF_BITS-1] ? mag_t'(-edge_q[e]) : mag_t'(edge_q[e]);
            den_next[e] = edge_p[e][DIFF_BITS-1] ? mag_t'(-edge_p[e]) : mag_t'(edge_p[e]);
        end
        sa_next.ok = (rej == '0) && !w_span_x[DIFF_BITS-1] && (w_span_x != '0)
                     && !w_span_y[DIFF_BITS-1] && (w_span_y != '0);
    end

    logic  sa_vld_reg;
    side_t sa_reg;
    mag_t  sa_num_reg [NUM_EDGES];
    mag_t  sa_den_reg [NUM_EDGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sa_vld_reg <= 1'b0;
        else
            sa_vld_reg <= s0_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        sa_reg <= sa_next;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            sa_num_reg[e] <= num_next[e];
            sa_den_reg[e] <= den_next[e];
        end
    end

    // ---------------------------------------------------------------- ratio dividers
    // ratio = |q| * 1.0 / |p|, capped at 1.0 + 1 ulp in SB
    logic [U_BITS-1:0] ratio_raw [NUM_EDGES];

    for (genvar e = 0; e < NUM_EDGES; e++)
    begin : g_ratio
        lcv_div #(
            .NUM_BITS (COORD_BITS + PARAM_FRAC_BITS),
            .DEN_BITS (COORD_BITS),
            .QUO_BITS (U_BITS)
        ) u_div (
            .clk (clk),
            .num ((COORD_BITS + PARAM_FRAC_BITS)'(sa_num_reg[e]) << PARAM_FRAC_BITS),
            .den (sa_den_reg[e]),
            .quo (ratio_raw[e])
        );
    end

    // side data rides alongside the dividers
    logic  rd_vld_reg [0:LR-1];
    side_t rd_reg     [0:LR-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LR; i++)
                rd_vld_reg[i] <= 1'b0;
        end
        else
        begin
            rd_vld_reg[0] <= sa_vld_reg;
            for (int i = 1; i < LR; i++)
                rd_vld_reg[i] <= rd_vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg[0] <= sa_reg;
        for (int i = 1; i < LR; i++)
            rd_reg[i] <= rd_reg[i-1];
    end

    // ---------------------------------------------------------------- SB: u1 / u2
    // u1 = max over entry ratios (from 0), u2 = min over exit ratios (from 1.0)
    logic [U_BITS-1:0] rcap [NUM_EDGES];
    logic [U_BITS-1:0] u1_next, u2_next;
    side_t             rd_out;

    always_comb
    begin
        rd_out  = rd_reg[LR-1];
        u1_next = '0;
        u2_next = U_ONE;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            rcap[e] = (ratio_raw[e] > U_CAP) ? U_CAP : ratio_raw[e];
            if (rd_out.entry[e] && rcap[e] > u1_next)
                u1_next = rcap[e];
            if (rd_out.exit_e[e] && rcap[e] < u2_next)
                u2_next = rcap[e];
        end
    end

    logic              sb_vld_reg;
    side_t             sb_reg;
    logic [U_BITS-1:0] sb_u1_reg, sb_u2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sb_vld_reg <= 1'b0;
        else
            sb_vld_reg <= rd_vld_reg[LR-1];
    end

    always_ff @(posedge clk)
    begin
        sb_reg    <= rd_out;
        sb_u1_reg <= u1_next;
        sb_u2_reg <= u2_next;
    end

    // ---------------------------------------------------------------- SC: u * d
    // coordinate order: start x, start y, end x, end y
    logic                       sc_vld_reg, sc_vis_reg;
    logic signed [PR_BITS-1:0]  sc_prod_reg [NUM_COORDS];
    coord_t                     sc_c_reg    [NUM_COORDS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_vld_reg <= 1'b0;
        else
            sc_vld_reg <= sb_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        sc_vis_reg     <= sb_reg.ok && (sb_u1_reg <= sb_u2_reg);
        sc_prod_reg[0] <= $signed({1'b0, sb_u1_reg}) * sb_reg.dx;
        sc_prod_reg[1] <= $signed({1'b0, sb_u1_reg}) * sb_reg.dy;
        sc_prod_reg[2] <= $signed({1'b0, sb_u2_reg}) * sb_reg.dx;
        sc_prod_reg[3] <= $signed({1'b0, sb_u2_reg}) * sb_reg.dy;
        sc_c_reg[0]    <= sb_reg.x1;
        sc_c_reg[1]    <= sb_reg.y1;
        sc_c_reg[2]    <= sb_reg.x1;
        sc_c_reg[3]    <= sb_reg.y1;
    end

    // ---------------------------------------------------------------- SD: round, relative
    // clipped = c*1.0 + u*d, rounded half up to 8 fraction bits, minus window min
    logic signed [X_BITS-1:0] xsum [NUM_COORDS];
    logic signed [X_BITS-1:0] xrnd [NUM_COORDS];
    logic signed [A_BITS-1:0] rel_next [NUM_COORDS];

    always_comb
    begin
        for (int j = 0; j < NUM_COORDS; j++)
        begin
            xsum[j] = (X_BITS'(sc_c_reg[j]) <<< PARAM_FRAC_BITS) + X_BITS'(sc_prod_reg[j]);
            xrnd[j] = (xsum[j] + RND) >>> SH;
            rel_next[j] = A_BITS'(xrnd[j])
                          - (A_BITS'((j % 2 == 0) ? wl_reg : wb_reg) <<< OUT_FRAC);
        end
    end

    logic                     sd_vld_reg, sd_vis_reg;
    logic signed [A_BITS-1:0] sd_rel_reg [NUM_COORDS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sd_vld_reg <= 1'b0;
        else
            sd_vld_reg <= sc_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        sd_vis_reg <= sc_vis_reg;
        for (int j = 0; j < NUM_COORDS; j++)
            sd_rel_reg[j] <= rel_next[j];
    end

    // ---------------------------------------------------------------- SE: scale by viewport span
    logic                     se_vld_reg, se_vis_reg;
    logic signed [T_BITS-1:0] se_t_reg [NUM_COORDS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            se_vld_reg <= 1'b0;
        else
            se_vld_reg <= sd_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        se_vis_reg <= sd_vis_reg;
        for (int j = 0; j < NUM_COORDS; j++)
            se_t_reg[j] <= sd_rel_reg[j] * ((j % 2 == 0) ? v_span_x : v_span_y);
    end

    // ---------------------------------------------------------------- SF: divider setup
    // floor((2t + ws) / 2ws) taken as an unsigned divide of n or ~n; a negative
    // numerator gives ~quotient, which is the floor.
    logic signed [N_BITS-1:0] nval [NUM_COORDS];
    logic [M_BITS-1:0]        mag_next [NUM_COORDS];
    logic [NUM_COORDS-1:0]    neg_next;

    always_comb
    begin
        for (int j = 0; j < NUM_COORDS; j++)
        begin
            nval[j] = (N_BITS'(se_t_reg[j]) <<< 1)
                      + N_BITS'((j % 2 == 0) ? w_span_x : w_span_y);
            neg_next[j] = nval[j][N_BITS-1];
            mag_next[j] = neg_next[j] ? M_BITS'(~nval[j]) : M_BITS'(nval[j]);
        end
    end

    logic                    sf_vld_reg, sf_vis_reg;
    logic [NUM_COORDS-1:0]   sf_neg_reg;
    logic [M_BITS-1:0]       sf_mag_reg [NUM_COORDS];
    logic [COORD_BITS:0]     sf_dx_reg, sf_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sf_vld_reg <= 1'b0;
        else
            sf_vld_reg <= se_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        sf_vis_reg <= se_vis_reg;
        sf_neg_reg <= neg_next;
        for (int j = 0; j < NUM_COORDS; j++)
            sf_mag_reg[j] <= mag_next[j];
        sf_dx_reg <= {w_span_x[COORD_BITS-1:0], 1'b0};
        sf_dy_reg <= {w_span_y[COORD_BITS-1:0], 1'b0};
    end

    // ---------------------------------------------------------------- mapping dividers
    logic [QB-1:0] map_quo [NUM_COORDS];

    for (genvar j = 0; j < NUM_COORDS; j++)
    begin : g_map
        lcv_div #(
            .NUM_BITS (M_BITS),
            .DEN_BITS (COORD_BITS + 1),
            .QUO_BITS (QB)
        ) u_div (
            .clk (clk),
            .num (sf_mag_reg[j]),
            .den ((j % 2 == 0) ? sf_dx_reg : sf_dy_reg),
            .quo (map_quo[j])
        );
    end

    logic                  md_vld_reg [0:LM-1];
    logic                  md_vis_reg [0:LM-1];
    logic [NUM_COORDS-1:0] md_neg_reg [0:LM-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LM; i++)
                md_vld_reg[i] <= 1'b0;
        end
        else
        begin
            md_vld_reg[0] <= sf_vld_reg;
            for (int i = 1; i < LM; i++)
                md_vld_reg[i] <= md_vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        md_vis_reg[0] <= sf_vis_reg;
        md_neg_reg[0] <= sf_neg_reg;
        for (int i = 1; i < LM; i++)
        begin
            md_vis_reg[i] <= md_vis_reg[i-1];
            md_neg_reg[i] <= md_neg_reg[i-1];
        end
    end

    // ---------------------------------------------------------------- SG: offset, saturate
    logic signed [QB:0]       qsig [NUM_COORDS];
    logic signed [V_BITS-1:0] vsum [NUM_COORDS];
    out_t                     vout [NUM_COORDS];
    res_t                     result_next;
    logic                     vis_out;

    always_comb
    begin
        vis_out = md_vis_reg[LM-1];
        for (int j = 0; j < NUM_COORDS; j++)
        begin
            qsig[j] = md_neg_reg[LM-1][j] ? ~$signed({1'b0, map_quo[j]})
                                           : $signed({1'b0, map_quo[j]});
            vsum[j] = V_BITS'(qsig[j])
                      + (V_BITS'((j % 2 == 0) ? vl_reg : vb_reg) <<< OUT_FRAC);
            if (!vis_out)
                vout[j] = '0;
            else if (vsum[j] > V_MAX)
                vout[j] = out_t'(V_MAX);
            else if (vsum[j] < V_MIN)
                vout[j] = out_t'(V_MIN);
            else
                vout[j] = out_t'(vsum[j]);
        end
        result_next.visible      = vis_out;
        result_next.view_start_x = vout[0];
        result_next.view_start_y = vout[1];
        result_next.view_end_x   = vout[2];
        result_next.view_end_y   = vout[3];
    end

    logic done_reg;
    res_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= md_vld_reg[LM-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
